/* rtl/core/afu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation function unit package
// Function codes, stage control struct and the exp helper used to build the
// sigmoid table at elaboration.
// ----------------------------------------------------------------------------
package afu_pkg;

  localparam int SEL_W = 3;

  localparam logic [SEL_W-1:0] FN_RELU      = 3'd0;
  localparam logic [SEL_W-1:0] FN_SIGMOID   = 3'd1;
  localparam logic [SEL_W-1:0] FN_TANH      = 3'd2;
  localparam logic [SEL_W-1:0] FN_RELU_D    = 3'd3;
  localparam logic [SEL_W-1:0] FN_SIGMOID_D = 3'd4;
  localparam logic [SEL_W-1:0] FN_TANH_D    = 3'd5;

  // sigmoid values are unsigned Q1.30, never above 1.0
  localparam int     FRAC_Q  = 30;
  localparam int     Q_W     = 31;
  localparam longint ONE_Q30 = 64'sd1 <<< FRAC_Q;

  typedef struct packed {
    logic             valid;
    logic [SEL_W-1:0] func;
    logic             neg;
  } afu_ctrl_t;

  // exp(-u) in Q30: series for exp(-u/16), then four squarings
  function automatic longint exp_neg_q30(input longint u);
    longint y;
    longint term;
    longint sum;
    int     n;
    y    = u >>> 4;
    term = ONE_Q30;
    sum  = ONE_Q30;
    term = ((term * y) >>> 30) / 1;  sum = sum - term;
    term = ((term * y) >>> 30) / 2;  sum = sum + term;
    term = ((term * y) >>> 30) / 3;  sum = sum - term;
    term = ((term * y) >>> 30) / 4;  sum = sum + term;
    term = ((term * y) >>> 30) / 5;  sum = sum - term;
    term = ((term * y) >>> 30) / 6;  sum = sum + term;
    term = ((term * y) >>> 30) / 7;  sum = sum - term;
    term = ((term * y) >>> 30) / 8;  sum = sum + term;
    term = ((term * y) >>> 30) / 9;  sum = sum - term;
    term = ((term * y) >>> 30) / 10; sum = sum + term;
    term = ((term * y) >>> 30) / 11; sum = sum - term;
    term = ((term * y) >>> 30) / 12; sum = sum + term;
    term = ((term * y) >>> 30) / 13; sum = sum - term;
    term = ((term * y) >>> 30) / 14; sum = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    for (n = 0; n < 4; n++) begin
      sum = (sum * sum + (64'sd1 <<< 29)) >>> 30;
    end
    return sum;
  endfunction

endpackage

/* rtl/core/afu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation front end
// Forms the sigmoid argument (x or 2x), its magnitude clamped to 8.0, and
// splits the scaled magnitude into a table index and an interpolation fraction.
// ----------------------------------------------------------------------------
module afu_front #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRACTION_BITS = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [DATA_WIDTH-1:0]           sample,
  input  logic [afu_pkg::SEL_W-1:0]              func,
  output afu_pkg::afu_ctrl_t                     ctrl,
  output logic signed [DATA_WIDTH-1:0]           x_out,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx,
  output logic [FRACTION_BITS+2:0]               frac
);
  import afu_pkg::*;

  localparam int AW  = (DATA_WIDTH + 1 > FRACTION_BITS + 4) ? DATA_WIDTH + 1 : FRACTION_BITS + 4;
  localparam int TIW = $clog2(TABLE_ENTRIES + 1);
  localparam int PW  = FRACTION_BITS + 3 + TIW;
  localparam logic [AW-1:0] RANGE = AW'(8) << FRACTION_BITS;

  logic signed [DATA_WIDTH:0]   arg;
  logic [DATA_WIDTH:0]          arg_mag;
  logic [AW-1:0]                mag_ext;
  logic [FRACTION_BITS+3:0]     clamped;
  logic [PW-1:0]                scaled;

  always_comb begin
    if (func == FN_TANH || func == FN_TANH_D) begin
      arg = {sample, 1'b0};
    end else begin
      arg = {sample[DATA_WIDTH-1], sample};
    end
    arg_mag = arg[DATA_WIDTH] ? $unsigned(-arg) : $unsigned(arg);
    mag_ext = AW'(arg_mag);
    clamped = (mag_ext > RANGE) ? RANGE[FRACTION_BITS+3:0] : mag_ext[FRACTION_BITS+3:0];
    scaled  = PW'(clamped) * PW'(TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    ctrl.valid <= in_valid;
    ctrl.func  <= func;
    ctrl.neg   <= arg[DATA_WIDTH];
    x_out      <= sample;
    idx        <= scaled[PW-1:FRACTION_BITS+3];
    frac       <= scaled[FRACTION_BITS+2:0];
    if (rst) begin
      ctrl.valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/afu_sigmoid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigmoid table and interpolation
// Constant table of sigmoid over [0, 8] in Q1.30, registered two-point read,
// linear interpolation multiply and add, then the odd-symmetry fold for negatives.
// ----------------------------------------------------------------------------
module afu_sigmoid #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRACTION_BITS = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  afu_pkg::afu_ctrl_t                     ctrl_in,
  input  logic signed [DATA_WIDTH-1:0]           x_in,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx,
  input  logic [FRACTION_BITS+2:0]               frac,
  output afu_pkg::afu_ctrl_t                     ctrl_out,
  output logic signed [DATA_WIDTH-1:0]           x_out,
  output logic [afu_pkg::Q_W-1:0]                sig
);
  import afu_pkg::*;

  localparam int TIW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW  = FRACTION_BITS + 3;
  localparam int PRW = Q_W + 1 + RW + 1;
  localparam int SW  = Q_W + 2;

  logic [Q_W-1:0] rom [TABLE_ENTRIES+1];

  for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_rom
    localparam longint U     = (64'(k) <<< 33) / TABLE_ENTRIES;
    localparam longint DEN   = ONE_Q30 + exp_neg_q30(U);
    localparam longint POINT = ((64'sd1 <<< 60) + DEN / 2) / DEN;
    assign rom[k] = Q_W'(POINT);
  end

  // stage: table read
  logic [TIW-1:0]         idx_hi;
  afu_ctrl_t              c2;
  logic signed [DATA_WIDTH-1:0] x2;
  logic [Q_W-1:0]         p0;
  logic [Q_W-1:0]         p1;
  logic [RW-1:0]          frac2;

  assign idx_hi = (idx == TIW'(TABLE_ENTRIES)) ? idx : idx + TIW'(1);

  // stage: interpolation product
  logic signed [Q_W:0]    diff;
  logic signed [PRW-1:0]  prod;
  afu_ctrl_t              c3;
  logic signed [DATA_WIDTH-1:0] x3;
  logic [Q_W-1:0]         p0_3;
  logic signed [PRW-1:0]  prod3;

  // stage: add and fold
  logic signed [PRW-1:0]  quot;
  logic signed [SW-1:0]   s_pos;
  logic signed [SW-1:0]   s_val;

  always_comb begin
    diff = $signed({1'b0, p1}) - $signed({1'b0, p0});
    prod = diff * $signed({1'b0, frac2});
  end

  always_comb begin
    // divide by 8<<FRACTION_BITS, truncating toward zero
    quot = prod3 >>> RW;
    if (prod3[PRW-1] && (prod3[RW-1:0] != '0)) begin
      quot = quot + PRW'(1);
    end
    s_pos = $signed({2'b00, p0_3}) + $signed(quot[SW-1:0]);
    s_val = c3.neg ? SW'(ONE_Q30) - s_pos : s_pos;
  end

  always_ff @(posedge clk) begin
    c2       <= ctrl_in;
    x2       <= x_in;
    p0       <= rom[idx];
    p1       <= rom[idx_hi];
    frac2    <= frac;
    c3       <= c2;
    x3       <= x2;
    p0_3     <= p0;
    prod3    <= prod;
    ctrl_out <= c3;
    x_out    <= x3;
    sig      <= s_val[Q_W-1:0];
    if (rst) begin
      c2.valid       <= 1'b0;
      c3.valid       <= 1'b0;
      ctrl_out.valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/afu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation back end
// Forms tanh from sigmoid, the derivative product, then rounds, selects the
// function, saturates and registers the result beat.
// ----------------------------------------------------------------------------
module afu_back #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  afu_pkg::afu_ctrl_t           ctrl_in,
  input  logic signed [DATA_WIDTH-1:0] x_in,
  input  logic [afu_pkg::Q_W-1:0]      sig,
  output logic                         result_valid,
  output logic signed [DATA_WIDTH-1:0] result_value
);
  import afu_pkg::*;

  localparam int TW   = Q_W + 2;
  localparam int MW   = 2 * Q_W;
  localparam int VW   = ((DATA_WIDTH > FRACTION_BITS + 2) ? DATA_WIDTH : FRACTION_BITS + 2) + 1;
  localparam int SH_V = FRAC_Q - FRACTION_BITS;
  localparam int SH_P = 2 * FRAC_Q - FRACTION_BITS;
  localparam logic [Q_W:0]     HALF_V  = (Q_W + 1)'(1) << (SH_V - 1);
  localparam logic [MW:0]      HALF_P  = (MW + 1)'(1) << (SH_P - 1);
  localparam logic [MW-1:0]    ONE_Q60 = MW'(1) << (2 * FRAC_Q);
  localparam logic signed [VW-1:0] ONE_FB = VW'(1) << FRACTION_BITS;
  localparam logic signed [VW-1:0] SAT_HI = (VW'(1) << (DATA_WIDTH - 1)) - VW'(1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

  // stage: tanh and derivative product
  logic signed [TW-1:0] t;
  logic [Q_W-1:0]       t_mag;
  logic [Q_W-1:0]       ma;
  logic [Q_W-1:0]       mb;
  logic [MW-1:0]        prod;

  afu_ctrl_t              c5;
  logic signed [DATA_WIDTH-1:0] x5;
  logic [Q_W-1:0]         sig5;
  logic [Q_W-1:0]         mag5;
  logic                   tneg5;
  logic [MW-1:0]          prod5;

  always_comb begin
    t     = $signed({1'b0, sig, 1'b0}) - TW'(ONE_Q30);
    t_mag = t[TW-1] ? Q_W'(-t) : Q_W'(t);
    if (ctrl_in.func == FN_TANH_D) begin
      ma = t_mag;
      mb = t_mag;
    end else begin
      ma = sig;
      mb = Q_W'(ONE_Q30) - sig;
    end
    prod = MW'(ma) * MW'(mb);
  end

  // stage: round, select, saturate
  logic [Q_W:0]         sig_sum;
  logic [Q_W:0]         mag_sum;
  logic [MW-1:0]        pd;
  logic [MW:0]          pd_sum;
  logic signed [VW-1:0] sig_rnd;
  logic signed [VW-1:0] tanh_rnd;
  logic signed [VW-1:0] prod_rnd;
  logic signed [VW-1:0] res;
  logic signed [VW-1:0] sat;

  always_comb begin
    sig_sum  = {1'b0, sig5} + HALF_V;
    mag_sum  = {1'b0, mag5} + HALF_V;
    sig_rnd  = VW'(sig_sum >> SH_V);
    tanh_rnd = VW'(mag_sum >> SH_V);
    if (tneg5) begin
      tanh_rnd = -tanh_rnd;
    end
    pd       = (c5.func == FN_TANH_D) ? ONE_Q60 - prod5 : prod5;
    pd_sum   = {1'b0, pd} + HALF_P;
    prod_rnd = VW'(pd_sum >> SH_P);

    unique case (c5.func)
      FN_RELU:      res = (x5 > 0) ? VW'(x5) : '0;
      FN_SIGMOID:   res = sig_rnd;
      FN_TANH:      res = tanh_rnd;
      FN_RELU_D:    res = (x5 > 0) ? ONE_FB : '0;
      FN_SIGMOID_D: res = prod_rnd;
      FN_TANH_D:    res = prod_rnd;
      default:      res = '0;
    endcase

    if (res > SAT_HI) begin
      sat = SAT_HI;
    end else if (res < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = res;
    end
  end

  always_ff @(posedge clk) begin
    c5           <= ctrl_in;
    x5           <= x_in;
    sig5         <= sig;
    mag5         <= t_mag;
    tneg5        <= t[TW-1];
    prod5        <= prod;
    result_valid <= c5.valid;
    result_value <= sat[DATA_WIDTH-1:0];
    if (rst) begin
      c5.valid     <= 1'b0;
      result_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/activation_function_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation function unit
// ReLU, sigmoid, tanh and their derivatives on signed fixed-point samples.
// ----------------------------------------------------------------------------
// One sample is taken in every clock cycle and its result appears on
// result_value, marked by a one-cycle result_valid strobe; there is no
// back-pressure, so the receiver must take every beat. busy never rises and
// cfg_ready is always high. The six register stages are argument prep, table
// read, interpolation multiply, interpolation add, derivative multiply and
// round/saturate; the table read and the two multipliers set the stage depth.
// function_select is sampled with each sample and travels with it.
module activation_function_unit #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRACTION_BITS = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] sample_value,
  output logic                         result_valid,
  output logic signed [DATA_WIDTH-1:0] result_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [afu_pkg::SEL_W-1:0]    cfg_data
);
  import afu_pkg::*;

  localparam int TIW = $clog2(TABLE_ENTRIES + 1);

  logic [SEL_W-1:0] function_select;

  afu_ctrl_t                    front_ctrl;
  logic signed [DATA_WIDTH-1:0] front_x;
  logic [TIW-1:0]               front_idx;
  logic [FRACTION_BITS+2:0]     front_frac;

  afu_ctrl_t                    sig_ctrl;
  logic signed [DATA_WIDTH-1:0] sig_x;
  logic [Q_W-1:0]               sig_val;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_select <= FN_RELU;
    end else if (cfg_valid && cfg_ready) begin
      function_select <= cfg_data;
    end
  end

  afu_front #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .sample   (sample_value),
    .func     (function_select),
    .ctrl     (front_ctrl),
    .x_out    (front_x),
    .idx      (front_idx),
    .frac     (front_frac)
  );

  afu_sigmoid #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_sigmoid (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (front_ctrl),
    .x_in     (front_x),
    .idx      (front_idx),
    .frac     (front_frac),
    .ctrl_out (sig_ctrl),
    .x_out    (sig_x),
    .sig      (sig_val)
  );

  afu_back #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ctrl_in      (sig_ctrl),
    .x_in         (sig_x),
    .sig          (sig_val),
    .result_valid (result_valid),
    .result_value (result_value)
  );

endmodule

/* tb/activation_function_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation function unit testbench
// Sends signed Q4.12 samples under every function code. A bit-exact fixed-point
// predictor gives the value that each sample should produce, and every result
// beat is checked in order against it. The function code is only changed
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import afu_pkg::*;

  localparam int DW          = 16;
  localparam int FB          = 12;
  localparam int TBL         = 256;
  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 60000;
  localparam int RAND_PHASES = 16;
  localparam int PHASE_ITEMS = 28;

  localparam logic [SEL_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [SEL_W-1:0] FN_SPARE_HI = 3'd7;

  localparam longint ARG_RANGE = longint'(8) << FB;
  localparam longint ONE_Q60   = 64'sd1 <<< 60;

  localparam logic signed [DW-1:0] S_MIN = 16'sh8000;
  localparam logic signed [DW-1:0] S_MAX = 16'sh7fff;

  typedef logic signed [DW-1:0] sample_t;

  typedef struct {
    logic [SEL_W-1:0] fsel;
    sample_t          sample;
    sample_t          value;
  } activation_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  sample_t          sample_value = '0;
  logic             result_valid;
  sample_t          result_value;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [SEL_W-1:0] cfg_data = '0;

  sample_t          queued_samples[$];
  activation_t      awaited_activations[$];
  longint           sigmoid_points[0:TBL];
  logic [SEL_W-1:0] active_func = FN_RELU;
  int               error_count = 0;
  int               cycle_count = 0;
  int               burst_left = 0;
  int               gap_left = 0;

  activation_function_unit #(
    .DATA_WIDTH   (DW),
    .FRACTION_BITS(FB),
    .TABLE_ENTRIES(TBL)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample_value(sample_value),
    .result_valid(result_valid),
    .result_value(result_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // exp(-u), u in Q30: series for exp(-u/16) squared four times
  function automatic longint exp_neg_fixed(input longint u);
    longint y;
    longint term;
    longint sum;
    int     n;
    y    = u >>> 4;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (n = 1; n <= 14; n++) begin
      term = ((term * y) >>> 30) / n;
      sum  = (n % 2 == 1) ? sum - term : sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    for (n = 0; n < 4; n++) begin
      sum = (sum * sum + (64'sd1 <<< 29)) >>> 30;
    end
    return sum;
  endfunction

  function automatic void build_sigmoid_points();
    longint u;
    longint den;
    for (int k = 0; k <= TBL; k++) begin
      u   = (longint'(k) <<< 33) / TBL;
      den = ONE_Q30 + exp_neg_fixed(u);
      sigmoid_points[k] = (ONE_Q60 + den / 2) / den;
    end
  endfunction

  // sigmoid in Q30 of an argument with FB fraction bits
  function automatic longint sigmoid_fixed(input longint x);
    longint a;
    longint p;
    longint r;
    longint s;
    int     i;
    a = (x < 0) ? -x : x;
    if (a > ARG_RANGE) begin
      a = ARG_RANGE;
    end
    p = a * TBL;
    i = int'(p / ARG_RANGE);
    r = p % ARG_RANGE;
    if (i >= TBL) begin
      s = sigmoid_points[TBL];
    end else begin
      s = sigmoid_points[i] +
          ((sigmoid_points[i+1] - sigmoid_points[i]) * r) / ARG_RANGE;
    end
    return (x < 0) ? ONE_Q30 - s : s;
  endfunction

  function automatic longint round_near(input longint unsigned v, input int sh);
    return longint'((v + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic sample_t activation_of(input logic [SEL_W-1:0] fsel,
                                            input sample_t smp);
    longint x;
    longint s;
    longint t;
    longint mag;
    longint res;
    x = smp;
    case (fsel)
      FN_RELU: begin
        res = (x > 0) ? x : 0;
      end
      FN_SIGMOID: begin
        res = round_near(sigmoid_fixed(x), 30 - FB);
      end
      FN_TANH: begin
        t   = 2 * sigmoid_fixed(2 * x) - ONE_Q30;
        mag = round_near((t < 0) ? -t : t, 30 - FB);
        res = (t < 0) ? -mag : mag;
      end
      FN_RELU_D: begin
        res = (x > 0) ? (longint'(1) << FB) : 0;
      end
      FN_SIGMOID_D: begin
        s   = sigmoid_fixed(x);
        res = round_near(s * (ONE_Q30 - s), 60 - FB);
      end
      FN_TANH_D: begin
        t   = 2 * sigmoid_fixed(2 * x) - ONE_Q30;
        mag = (t < 0) ? -t : t;
        res = round_near(ONE_Q60 - mag * mag, 60 - FB);
      end
      default: begin
        res = 0;
      end
    endcase
    if (res > longint'(S_MAX)) begin
      res = S_MAX;
    end else if (res < longint'(S_MIN)) begin
      res = S_MIN;
    end
    return res[DW-1:0];
  endfunction

  // biased toward zero, the tanh knee where 2x meets the clamp, the full-scale edges and table points
  function automatic sample_t random_sample();
    int k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 5))
      0: return sample_t'($urandom_range(0, 1023) - 512);
      1: return $urandom_range(0, 1) ? sample_t'(16384 + k - 32) : sample_t'(-16384 + k - 32);
      2: return $urandom_range(0, 1) ? sample_t'(S_MAX - k) : sample_t'(S_MIN + k);
      3: return sample_t'(($urandom_range(0, 511) - 256) * 128 + $urandom_range(0, 2) - 1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_activations.push_back('{fsel: active_func, sample: sample_value,
                                        value: activation_of(active_func, sample_value)});
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (queued_samples.size() > 0) begin
          start        <= 1'b1;
          sample_value <= queued_samples.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(30, 90);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result beats cannot be held off, so every strobe is taken
  always @(posedge clk) begin
    activation_t want;
    if (!rst && result_valid) begin
      if (awaited_activations.size() == 0) begin
        $display("%0t: result %0d with nothing awaited", $time, result_value);
        error_count++;
      end else begin
        want = awaited_activations.pop_front();
        if (result_value !== want.value) begin
          $display("%0t: fn %0d sample %0d: expected %0d, got %0d", $time,
                   want.fsel, want.sample, want.value, result_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // checked mid-cycle so the sender's and monitor's edge updates have settled
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (queued_samples.size() != 0 || start || awaited_activations.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_function(input logic [SEL_W-1:0] fsel);
    cfg_data  <= fsel;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid   <= 1'b0;
    active_func = fsel;
  endtask

  task automatic run_phase(input logic [SEL_W-1:0] fsel, input bit do_write,
                           input sample_t samples[$]);
    wait_idle();
    if (do_write) begin
      write_function(fsel);
    end
    queued_samples = samples;
  endtask

  initial begin
    sample_t batch[$];
    build_sigmoid_points();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // relu straight out of reset, then every code with its edge cases
    run_phase(FN_RELU, 1'b0, '{S_MIN, 16'sd0, 16'sd1, S_MAX});
    run_phase(FN_SIGMOID, 1'b1, '{S_MIN, S_MAX, 16'sd0, 16'sd128});
    run_phase(FN_TANH, 1'b1, '{-16'sd16385, 16'sd16385, -16'sd1});
    run_phase(FN_RELU_D, 1'b1, '{16'sd0, 16'sd1, -16'sd1});
    run_phase(FN_SIGMOID_D, 1'b1, '{16'sd0, S_MIN});
    run_phase(FN_TANH_D, 1'b1, '{16'sd0, 16'sd16384, S_MIN});
    run_phase(FN_SPARE_LO, 1'b1, '{16'sd4096});
    run_phase(FN_SPARE_HI, 1'b1, '{-16'sd4096});

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      batch = {};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        batch.push_back(random_sample());
      end
      run_phase((ph < 8) ? ph[SEL_W-1:0] : SEL_W'($urandom_range(0, 7)), 1'b1, batch);
    end

    wait_idle();
    repeat (LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/afu_pkg.sv
rtl/core/afu_front.sv
rtl/core/afu_sigmoid.sv
rtl/core/afu_back.sv
rtl/core/activation_function_unit.sv
tb/activation_function_unit_tb.sv
